@@ hdl/mime_base64_line_encoder_defines.svh @@
// Assertion helpers used by the RTL.
`ifndef MIME_BASE64_LINE_ENCODER_DEFINES_SVH
`define MIME_BASE64_LINE_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MB64_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MB64_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mb64_pkg.sv @@
`timescale 1ns / 1ps

package mb64_pkg;

  localparam int LINE_BYTES = 54;
  localparam int GROUPS_RAW = LINE_BYTES / 3;
  localparam int GROUPS_PER_LINE = (GROUPS_RAW < 1) ? 1 :
                                   ((GROUPS_RAW > 31) ? 31 : GROUPS_RAW);
  localparam int PER_LINE_CHARS = GROUPS_PER_LINE * 4 + 2;

  localparam int RUN_MAX = 6;
  localparam int IDX_W = 3;

  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_PAD = 8'd61;

  localparam logic [IDX_W-1:0] RUN_QUAD = 3'd4;
  localparam logic [IDX_W-1:0] RUN_LINE = 3'd6;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] chars;
    logic [IDX_W-1:0]        n;
    logic [31:0]             cnt;
  } run_t;

  function automatic logic [7:0] sextet(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

@@ hdl/mb64_enc.sv @@
`timescale 1ns / 1ps

module mb64_enc
  import mb64_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_data_byte,
  output logic       run_valid,
  input  logic       run_ready,
  output run_t       run
);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [4:0]  gil_r, gil_nxt;
  logic [31:0] line_chars_r, line_chars_nxt;
  logic        run_valid_r, run_valid_nxt;
  run_t        run_r, run_nxt;

  logic        in_acc;
  logic        produce;
  logic [7:0]  addend;
  logic [5:0]  begun;
  logic [4:0]  gil_inc;
  logic        line_done;
  logic [32:0] sum;
  logic [31:0] total;
  logic [7:0]  b0, b1;
  logic [23:0] w;

  assign in_stall = run_valid_r && !run_ready;
  assign in_acc   = in_valid && !in_stall;
  assign run_valid = run_valid_r;
  assign run       = run_r;

  assign gil_inc   = gil_r + 5'd1;
  assign line_done = (gil_inc == 5'(GROUPS_PER_LINE));
  assign w         = {held_r, in_data_byte};

  always_comb begin
    held_nxt       = held_r;
    pos_nxt        = pos_r;
    gil_nxt        = gil_r;
    line_chars_nxt = line_chars_r;
    run_nxt        = run_r;
    produce        = 1'b0;
    begun          = 6'd0;
    addend         = 8'd0;
    b0             = held_r[15:8];
    b1             = held_r[7:0];

    if (in_kind) begin
      begun  = {1'b0, gil_r} + {5'd0, (pos_r != 2'd0)};
      addend = {begun, 2'b00};
    end else if (line_done) begin
      addend = 8'(PER_LINE_CHARS);
    end else begin
      begun  = {1'b0, gil_inc};
      addend = {begun, 2'b00};
    end

    sum   = {1'b0, line_chars_r} + {25'd0, addend};
    total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    run_nxt.cnt = total;

    if (in_kind) begin
      case (pos_r)
        2'd0: begin
          produce = 1'b0;
        end
        2'd1: begin
          b0 = held_r[7:0];
          produce = 1'b1;
          run_nxt.chars[0] = sextet(b0[7:2]);
          run_nxt.chars[1] = sextet({b0[1:0], 4'b0000});
          run_nxt.chars[2] = CH_PAD;
          run_nxt.chars[3] = CH_PAD;
          run_nxt.n = RUN_QUAD;
        end
        default: begin
          produce = 1'b1;
          run_nxt.chars[0] = sextet(b0[7:2]);
          run_nxt.chars[1] = sextet({b0[1:0], b1[7:4]});
          run_nxt.chars[2] = sextet({b1[3:0], 2'b00});
          run_nxt.chars[3] = CH_PAD;
          run_nxt.n = RUN_QUAD;
        end
      endcase
      held_nxt       = 16'd0;
      pos_nxt        = 2'd0;
      gil_nxt        = 5'd0;
      line_chars_nxt = 32'd0;
    end else if (pos_r < 2'd2) begin
      held_nxt = {held_r[7:0], in_data_byte};
      pos_nxt  = pos_r + 2'd1;
    end else begin
      produce = 1'b1;
      run_nxt.chars[0] = sextet(w[23:18]);
      run_nxt.chars[1] = sextet(w[17:12]);
      run_nxt.chars[2] = sextet(w[11:6]);
      run_nxt.chars[3] = sextet(w[5:0]);
      run_nxt.chars[4] = CH_CR;
      run_nxt.chars[5] = CH_LF;
      run_nxt.n = line_done ? RUN_LINE : RUN_QUAD;
      held_nxt = 16'd0;
      pos_nxt  = 2'd0;
      if (line_done) begin
        gil_nxt        = 5'd0;
        line_chars_nxt = total;
      end else begin
        gil_nxt = gil_inc;
      end
    end

    run_valid_nxt = run_valid_r && !run_ready;
    if (in_acc && produce) begin
      run_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= 16'd0;
      pos_r        <= 2'd0;
      gil_r        <= 5'd0;
      line_chars_r <= 32'd0;
      run_valid_r  <= 1'b0;
    end else begin
      run_valid_r <= run_valid_nxt;
      if (in_acc) begin
        held_r       <= held_nxt;
        pos_r        <= pos_nxt;
        gil_r        <= gil_nxt;
        line_chars_r <= line_chars_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && produce) begin
      run_r <= run_nxt;
    end
  end

endmodule

@@ hdl/mb64_ser.sv @@
`timescale 1ns / 1ps

`include "mime_base64_line_encoder_defines.svh"

module mb64_ser
  import mb64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        run_valid,
  output logic        run_ready,
  input  run_t        run,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last_of_run,
  output logic [31:0] out_chars_written
);

  logic             act_valid_r, act_valid_nxt;
  run_t             act_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r;
  logic             out_last_r;
  logic [31:0]      out_cnt_r;

  logic load_out;
  logic at_end;
  logic take_run;

  assign load_out  = !out_valid_r || !out_stall;
  assign at_end    = (idx_r == act_r.n - 3'd1);
  assign run_ready = !act_valid_r || (load_out && at_end);
  assign take_run  = run_valid && run_ready;

  always_comb begin
    act_valid_nxt = act_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = act_valid_r;
      if (act_valid_r) begin
        idx_nxt = idx_r + 3'd1;
        if (at_end) begin
          act_valid_nxt = 1'b0;
        end
      end
    end
    if (take_run) begin
      act_valid_nxt = 1'b1;
      idx_nxt       = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      act_valid_r <= act_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_run) begin
      act_r <= run;
    end
    if (load_out && act_valid_r) begin
      out_char_r <= act_r.chars[idx_r];
      out_last_r <= at_end;
      out_cnt_r  <= act_r.cnt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_char          = out_char_r;
  assign out_last_of_run   = out_last_r;
  assign out_chars_written = out_cnt_r;

  `MB64_ASSERT_NOW(a_idx_in_run, clk, rst_n, act_valid_r, idx_r < act_r.n, "index past run")
  `MB64_ASSERT_NOW(a_run_len, clk, rst_n, act_valid_r,
                   act_r.n == RUN_QUAD || act_r.n == RUN_LINE, "bad run length")
  `MB64_ASSERT_NEXT(a_run_loaded, clk, rst_n, take_run,
                    act_valid_r && idx_r == 3'd0, "run not loaded")
  `MB64_ASSERT_NEXT(a_last_drops, clk, rst_n, load_out && act_valid_r && at_end && !take_run,
                    !act_valid_r && out_last_r, "run end not marked")

endmodule

@@ hdl/mime_base64_line_encoder.sv @@
`timescale 1ns / 1ps

// Base64 encoder with MIME line wrap.
// Input channel (in_valid/in_stall): one item per transfer, in_kind 0 carries
// in_data_byte, in_kind 1 flushes one or two pending bytes with '=' padding
// and clears all state. Output channel (out_valid/out_stall): one character
// per transfer with out_last_of_run on the final character of an item and
// out_chars_written as the running count after that item.
// Every third byte yields four characters, plus CR LF at the end of a line.
// Throughput: one character per cycle through the output serializer while
// out_stall is low; bytes that complete no group are taken one per cycle
// while in_stall is low. A one-entry run buffer lets the next item be taken
// while the current run drains.
// Reset (rst_n low, synchronous) empties both stages and clears line state.
// While out_stall is high the output holds and, once the run buffer is full,
// in_stall rises.
module mime_base64_line_encoder
  import mb64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last_of_run,
  output logic [31:0] out_chars_written
);

  logic run_valid;
  logic run_ready;
  run_t run;

  mb64_enc u_enc (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .run_valid    (run_valid),
    .run_ready    (run_ready),
    .run          (run)
  );

  mb64_ser u_ser (
    .clk               (clk),
    .rst_n             (rst_n),
    .run_valid         (run_valid),
    .run_ready         (run_ready),
    .run               (run),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char          (out_char),
    .out_last_of_run   (out_last_of_run),
    .out_chars_written (out_chars_written)
  );

endmodule

@@ bench/mime_base64_line_encoder_tb.sv @@
`timescale 1ns / 1ps

module mime_base64_line_encoder_tb;
  import mb64_pkg::*;

  localparam bit KIND_DATA   = 1'b0;
  localparam bit KIND_FINISH = 1'b1;

  localparam bit [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  localparam int LINE_GROUPS = (LINE_BYTES / 3 < 1) ? 1 :
                               ((LINE_BYTES / 3 > 31) ? 31 : LINE_BYTES / 3);

  typedef struct {
    logic [7:0]  ch;
    logic        last;
    logic [31:0] count;
  } char_rec_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char;
  logic        out_last_of_run;
  logic [31:0] out_chars_written;

  mime_base64_line_encoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_last_of_run  (out_last_of_run),
    .out_chars_written(out_chars_written)
  );

  // encoder state mirror
  bit [15:0] carry_bytes;
  int        carry_count;
  int        line_groups;
  bit [31:0] lines_done;

  char_rec_t pending_chars[$];
  char_rec_t due;

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int chars_checked;
  int line_breaks;
  int flushes;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("mime_base64_line_encoder_tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  function automatic bit [7:0] b64_symbol(input bit [5:0] v);
    return ALPHABET[511 - 8 * v -: 8];
  endfunction

  function automatic bit [31:0] chars_so_far();
    bit [63:0] total;
    total = 64'(lines_done) * (LINE_GROUPS * 4 + 2) +
            64'(line_groups + (carry_count > 0 ? 1 : 0)) * 4;
    return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  function automatic void encode_item(input bit kind, input bit [7:0] b);
    bit [7:0]  run[$];
    bit [23:0] w;
    bit [31:0] cnt;
    char_rec_t rec;
    if (kind == KIND_FINISH) begin
      if (carry_count == 1) begin
        w = {carry_bytes[7:0], 16'h0};
        run.push_back(b64_symbol(w[23:18]));
        run.push_back(b64_symbol(w[17:12]));
        run.push_back(CH_PAD);
        run.push_back(CH_PAD);
      end else if (carry_count == 2) begin
        w = {carry_bytes, 8'h0};
        run.push_back(b64_symbol(w[23:18]));
        run.push_back(b64_symbol(w[17:12]));
        run.push_back(b64_symbol(w[11:6]));
        run.push_back(CH_PAD);
      end
      if (run.size() != 0) flushes++;
      cnt = chars_so_far();
      carry_bytes = '0;
      carry_count = 0;
      line_groups = 0;
      lines_done = '0;
    end else if (carry_count < 2) begin
      carry_bytes = {carry_bytes[7:0], b};
      carry_count++;
      return;
    end else begin
      w = {carry_bytes, b};
      run.push_back(b64_symbol(w[23:18]));
      run.push_back(b64_symbol(w[17:12]));
      run.push_back(b64_symbol(w[11:6]));
      run.push_back(b64_symbol(w[5:0]));
      carry_bytes = '0;
      carry_count = 0;
      line_groups++;
      if (line_groups >= LINE_GROUPS) begin
        run.push_back(CH_CR);
        run.push_back(CH_LF);
        line_groups = 0;
        if (lines_done != 32'hFFFF_FFFF) lines_done++;
      end
      cnt = chars_so_far();
    end
    foreach (run[i]) begin
      rec.ch = run[i];
      rec.last = (i == run.size() - 1);
      rec.count = cnt;
      pending_chars.push_back(rec);
    end
  endfunction

  task automatic send_item(input bit kind, input bit [7:0] b);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    items_sent++;
    encode_item(kind, b);
  endtask

  task automatic send_segment(input int n_bytes, input bit closed);
    repeat (n_bytes) send_item(KIND_DATA, 8'($urandom_range(255)));
    if (closed) send_item(KIND_FINISH, 8'($urandom_range(255)));
  endtask

  // transfer is taken at the next rising edge; sample mid-cycle
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected char %h last %b count %0d", $time,
                   out_char, out_last_of_run, out_chars_written);
      end else begin
        due = pending_chars.pop_front();
        if (out_char !== due.ch || out_last_of_run !== due.last ||
            out_chars_written !== due.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: exp char %h last %b count %0d, got %h %b %0d", $time,
                     due.ch, due.last, due.count, out_char, out_last_of_run,
                     out_chars_written);
        end else if (due.ch == CH_CR) begin
          line_breaks++;
        end
      end
    end
  end

  task automatic test_finish_when_empty();
    send_item(KIND_FINISH, 8'hA5);
    send_item(KIND_FINISH, 8'h00);
  endtask

  task automatic test_byte_extremes();
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, 8'hFB);
    send_item(KIND_DATA, 8'hEF);
    send_item(KIND_DATA, 8'hBE);
    send_item(KIND_FINISH, 8'hFF);
  endtask

  task automatic test_flush_one_byte();
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_FINISH, 8'h5A);
    send_item(KIND_DATA, 8'h01);
    send_item(KIND_DATA, 8'h02);
    send_item(KIND_DATA, 8'h03);
    send_item(KIND_DATA, 8'h80);
    send_item(KIND_FINISH, 8'hFF);
  endtask

  task automatic test_flush_two_bytes();
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'h0F);
    send_item(KIND_FINISH, 8'hFF);
  endtask

  task automatic test_random_stream(input int snd_pct, input int rcv_pct,
                                    input bit full_line_first);
    int sent_here;
    int roll;
    int n;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent_here = 0;
    if (full_line_first) begin
      n = $urandom_range(LINE_BYTES, LINE_BYTES + 8);
      send_segment(n, 1'b1);
      sent_here += n + 1;
    end
    while (sent_here < 15) begin
      roll = $urandom_range(99);
      if (roll < 5) n = $urandom_range(LINE_BYTES, LINE_BYTES + 6);
      else if (roll < 20) n = 0;
      else n = $urandom_range(1, 9);
      // mostly closed by a finish; sometimes bytes run on into the next
      send_segment(n, $urandom_range(99) < 85);
      sent_here += n + 1;
    end
  endtask

  task automatic drain_and_report();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d items; checked %0d chars incl. %0d line breaks and %0d flushes.",
             items_sent, chars_checked, line_breaks, flushes);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("mime_base64_line_encoder_tb: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("mime_base64_line_encoder_tb: FAIL");
    end
    $finish;
  endtask

  initial begin
    carry_bytes = '0;
    carry_count = 0;
    line_groups = 0;
    lines_done = '0;
    items_sent = 0;
    chars_checked = 0;
    line_breaks = 0;
    flushes = 0;
    mismatches = 0;
    send_idle_pct = 35;
    recv_idle_pct = 77;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_finish_when_empty();
    test_byte_extremes();
    test_flush_one_byte();
    test_flush_two_bytes();
    test_random_stream(35, 77, 1'b1);
    test_random_stream(77, 35, 1'b0);
    test_random_stream(0, 0, 1'b0);
    drain_and_report();
  end

endmodule
